// ===== design/rc2_pkg.sv =====
// Shared constants, operation codes and round helpers for the RC2 cipher core.
`default_nettype none

package rc2_pkg;

    // Key store geometry
    localparam int KEY_WORDS = 64;
    localparam int KEY_AW    = $clog2(KEY_WORDS);

    // Round structure
    localparam int RND_W              = 4;
    localparam logic [RND_W-1:0] RND_FIRST = 4'd0;
    localparam logic [RND_W-1:0] RND_LAST  = 4'd15;
    localparam logic [RND_W-1:0] MASH_RND_A = 4'd4;
    localparam logic [RND_W-1:0] MASH_RND_B = 4'd10;

    // Word position within a round
    localparam logic [1:0] WORD_FIRST = 2'd0;
    localparam logic [1:0] WORD_LAST  = 2'd3;

    // Operation codes of an input transaction
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD_KEY = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT  = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT  = 2'd2;

    // Select term f(a,b,c) = (a & ~c) + (b & c), modulo 2^16
    function automatic logic [15:0] sel16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
        sel16 = (a & ~c) + (b & c);
    endfunction

    // Left rotate by the mixing amount of word j (1, 2, 3, 5)
    function automatic logic [15:0] rol_mix(input logic [15:0] v, input logic [1:0] j);
        case (j)
            2'd0:    rol_mix = {v[14:0], v[15]};
            2'd1:    rol_mix = {v[13:0], v[15:14]};
            2'd2:    rol_mix = {v[12:0], v[15:13]};
            default: rol_mix = {v[10:0], v[15:11]};
        endcase
    endfunction

    // Right rotate by the mixing amount of word j (1, 2, 3, 5)
    function automatic logic [15:0] ror_mix(input logic [15:0] v, input logic [1:0] j);
        case (j)
            2'd0:    ror_mix = {v[0], v[15:1]};
            2'd1:    ror_mix = {v[1:0], v[15:2]};
            2'd2:    ror_mix = {v[2:0], v[15:3]};
            default: ror_mix = {v[4:0], v[15:5]};
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/rc2_block_cipher_core.sv =====
// RC2 block cipher core: key store memory, round sequencer and block datapath.
// Each block transaction runs 64 mixing steps and 8 mashing steps, then moves the result
// into the output register once the output is free, which raises m_valid. A new block or
// key load is accepted only in idle, after the previous block has moved out. The single
// key store read port serves one key word per cycle. A key load gives no result.
// Reset: synchronous, active low; returns the control state to idle and clears the output valid.
// The key store is not cleared and holds undefined data until written.
`default_nettype none

module rc2_block_cipher_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rc2_pkg::OP_W-1:0]  s_op,
    input  logic [rc2_pkg::KEY_AW-1:0] s_key_index,
    input  logic [15:0]               s_key_word,
    input  logic [15:0]               s_in_word0,
    input  logic [15:0]               s_in_word1,
    input  logic [15:0]               s_in_word2,
    input  logic [15:0]               s_in_word3,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [15:0]               m_out_word0,
    output logic [15:0]               m_out_word1,
    output logic [15:0]               m_out_word2,
    output logic [15:0]               m_out_word3
);
    import rc2_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t            state_reg;
    logic              dec_reg;
    logic              mash_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [1:0]        j_reg;
    // Rotating word window: win_reg[0] is always the word being updated
    logic [15:0]       win_reg [4];
    logic [15:0]       win_next [4];
    logic              m_valid_reg;
    logic [15:0]       out_reg [4];

    logic [15:0]       key_mem [KEY_WORDS];
    logic [15:0]       key_rd_reg;
    logic [KEY_AW-1:0] rd_addr;

    logic              s_take;
    logic              key_load;
    logic              blk_start;
    logic              out_free;

    logic [15:0]       sel_term;
    logic [15:0]       word_new;
    logic              mash_next;
    logic [RND_W-1:0]  rnd_next;
    logic [1:0]        j_next;
    logic              last_step;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign key_load  = s_take && (s_op == OP_LOAD_KEY);
    assign blk_start = s_take && ((s_op == OP_ENCRYPT) || (s_op == OP_DECRYPT));
    assign out_free  = !m_valid_reg || m_ready;

    // Word update for the current step
    always_comb begin
        sel_term = sel16(win_reg[1], win_reg[2], win_reg[3]);
        case ({dec_reg, mash_reg})
            2'b00:   word_new = rol_mix(win_reg[0] + sel_term + key_rd_reg, j_reg);
            2'b01:   word_new = win_reg[0] + key_rd_reg;
            2'b11:   word_new = win_reg[0] - key_rd_reg;
            default: word_new = ror_mix(win_reg[0], j_reg) - sel_term - key_rd_reg;
        endcase
    end

    // Window rotation: left for encrypt (ascending words), right for decrypt
    always_comb begin
        if (!dec_reg) begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = word_new;
        end else begin
            win_next[0] = win_reg[3];
            win_next[1] = word_new;
            win_next[2] = win_reg[1];
            win_next[3] = win_reg[2];
        end
    end

    // Step sequencer: next round, word and mash flag
    always_comb begin
        mash_next = mash_reg;
        rnd_next  = rnd_reg;
        j_next    = j_reg;
        last_step = 1'b0;
        if (!dec_reg) begin
            if (j_reg != WORD_LAST) begin
                j_next = j_reg + 2'd1;
            end else if (!mash_reg && ((rnd_reg == MASH_RND_A) || (rnd_reg == MASH_RND_B))) begin
                mash_next = 1'b1;
                j_next    = WORD_FIRST;
            end else begin
                last_step = (rnd_reg == RND_LAST);
                mash_next = 1'b0;
                rnd_next  = rnd_reg + 4'd1;
                j_next    = WORD_FIRST;
            end
        end else begin
            if (j_reg != WORD_FIRST) begin
                j_next = j_reg - 2'd1;
            end else if (mash_reg) begin
                mash_next = 1'b0;
                j_next    = WORD_LAST;
            end else begin
                last_step = (rnd_reg == RND_FIRST);
                rnd_next  = rnd_reg - 4'd1;
                mash_next = ((rnd_reg - 4'd1) == MASH_RND_A) ||
                            ((rnd_reg - 4'd1) == MASH_RND_B);
                j_next    = WORD_LAST;
            end
        end
    end

    // Key read address for the step after this one
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_addr = (s_op == OP_DECRYPT) ? {RND_LAST, WORD_LAST} : {RND_FIRST, WORD_FIRST};
        end else if (mash_next) begin
            rd_addr = win_next[3][KEY_AW-1:0];
        end else begin
            rd_addr = {rnd_next, j_next};
        end
    end

    // Key store: one write port for key loads, one registered read port
    always_ff @(posedge aclk) begin
        if (key_load) begin
            key_mem[s_key_index] <= s_key_word;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    // Control state, block window and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // Output valid: set when a finished block moves out, cleared when taken
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (blk_start) begin
                        state_reg <= ST_RUN;
                        dec_reg   <= (s_op == OP_DECRYPT);
                        mash_reg  <= 1'b0;
                        if (s_op == OP_DECRYPT) begin
                            rnd_reg    <= RND_LAST;
                            j_reg      <= WORD_LAST;
                            win_reg[0] <= s_in_word3;
                            win_reg[1] <= s_in_word0;
                            win_reg[2] <= s_in_word1;
                            win_reg[3] <= s_in_word2;
                        end else begin
                            rnd_reg    <= RND_FIRST;
                            j_reg      <= WORD_FIRST;
                            win_reg[0] <= s_in_word0;
                            win_reg[1] <= s_in_word1;
                            win_reg[2] <= s_in_word2;
                            win_reg[3] <= s_in_word3;
                        end
                    end
                end
                ST_RUN: begin
                    win_reg  <= win_next;
                    mash_reg <= mash_next;
                    rnd_reg  <= rnd_next;
                    j_reg    <= j_next;
                    if (last_step) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                        if (dec_reg) begin
                            out_reg[0] <= win_reg[1];
                            out_reg[1] <= win_reg[2];
                            out_reg[2] <= win_reg[3];
                            out_reg[3] <= win_reg[0];
                        end else begin
                            out_reg <= win_reg;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_word0 = out_reg[0];
    assign m_out_word1 = out_reg[1];
    assign m_out_word2 = out_reg[2];
    assign m_out_word3 = out_reg[3];

endmodule

`default_nettype wire
